/* rtl/srs_pkg.sv */
// Shared types and constants of the stereo linear resampler.
`timescale 1ns / 1ps

package srs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int RATE_W      = 16;
    localparam int MAX_RATE    = 48000;
    localparam int MAX_RESULTS = 8;

    // Time gap: stored 18-bit signed, working width one bit wider.
    localparam int GAP_W   = 18;
    localparam int FRAC_W  = GAP_W + 1;
    localparam int PROD_W  = SAMPLE_BITS + FRAC_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam int MUL_STEPS = 4;
    localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
    localparam int DIV_STEPS = ACC_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam int ADDR_W = 3;
    localparam logic [RATE_W-1:0] OUTPUT_RATE_RESET = RATE_W'(48000);
    localparam logic [RATE_W-1:0] INPUT_RATE_RESET  = RATE_W'(44100);

    // Register indexes, as decoded from paddr[2].
    localparam logic REG_OUTPUT_RATE = 1'b0;
    localparam logic REG_INPUT_RATE  = 1'b1;

    // Action codes.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_MUL,
        BK_DSET,
        BK_DIV,
        BK_EMIT,
        BK_FLUSH
    } back_state_t;

endpackage

/* rtl/srs_front.sv */
// Front end: accepts input words, drops ignored ones, tracks end of stream.
`timescale 1ns / 1ps

module srs_front
    import srs_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          rates_ok,
    input  logic                          q_full,
    output logic                          q_push,
    output cmd_t                          q_data
);

    logic finished_reg;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    // Forward only words that do real work.
    assign q_push = accept && rates_ok && !finished_reg;

    assign q_data.action = action;
    assign q_data.left   = left_sample;
    assign q_data.right  = right_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg <= 1'b0;
        end
        else if (q_push && action == ACT_FLUSH)
        begin
            finished_reg <= 1'b1;
        end
    end

endmodule

/* rtl/srs_cmd_queue.sv */
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module srs_cmd_queue
    import srs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/srs_back.sv */
// Back end: interpolation sequencer with shared multiplier and two dividers.
`timescale 1ns / 1ps

module srs_back
    import srs_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  cmd_t                          cmd_head,
    output logic                          cmd_pop,
    input  logic [RATE_W-1:0]             orate,
    input  logic [RATE_W-1:0]             irate,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic                          last,
    output logic                          empty,
    input  logic                          pop
);

    localparam logic signed [FRAC_W-1:0] GAP_MAX = FRAC_W'((1 << (GAP_W - 1)) - 1);
    localparam logic signed [FRAC_W-1:0] GAP_MIN = -FRAC_W'(1 << (GAP_W - 1));

    back_state_t state_reg, state_next;

    logic                          action_reg;
    logic signed [SAMPLE_BITS-1:0] new_l_reg, new_r_reg;
    logic signed [SAMPLE_BITS-1:0] held_l_reg, held_r_reg;
    logic                          started_reg;
    logic signed [GAP_W-1:0]       gap_reg;
    logic [CNT_W-1:0]              n_reg;
    logic [MCNT_W-1:0]             mcnt_reg;
    logic [DCNT_W-1:0]             dcnt_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_l_reg, acc_r_reg;
    logic [ACC_W-1:0]              dq_l_reg, dq_r_reg;
    logic [RATE_W-1:0]             rem_l_reg, rem_r_reg;
    logic                          neg_l_reg, neg_r_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic                          out_last_reg;

    logic signed [FRAC_W-1:0]      gap_x, orate_x, irate_x, frac;
    logic signed [FRAC_W-1:0]      gap_dec, gap_plus, gap_clamped;
    logic                          go_sample, go_flush, room;
    logic                          out_free, emit_fire, sample_done, emit_last;
    logic signed [SAMPLE_BITS-1:0] op_a;
    logic signed [FRAC_W-1:0]      op_b;
    logic signed [PROD_W-1:0]      mul_res;
    logic signed [ACC_W-1:0]       prod_x;
    logic [RATE_W+ACC_W-1:0]       step_l, step_r;
    logic [SAMPLE_BITS-1:0]        q_l, q_r;
    logic signed [SAMPLE_BITS-1:0] val_l, val_r;

    // One restoring division step: returns {remainder, shifted dividend/quotient}.
    function automatic logic [RATE_W+ACC_W-1:0] div_step(
        input logic [RATE_W-1:0] rem,
        input logic [ACC_W-1:0]  dq,
        input logic [RATE_W-1:0] d
    );
        logic [RATE_W:0]   trial;
        logic [RATE_W:0]   diff;
        logic              ge;
        logic [RATE_W-1:0] rem_new;
        trial   = {rem, dq[ACC_W-1]};
        diff    = trial - {1'b0, d};
        ge      = (trial >= {1'b0, d});
        rem_new = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        return {rem_new, dq[ACC_W-2:0], ge};
    endfunction

    assign gap_x    = FRAC_W'(gap_reg);
    assign orate_x  = $signed(FRAC_W'(orate));
    assign irate_x  = $signed(FRAC_W'(irate));
    assign frac     = orate_x - gap_x;
    assign gap_dec  = gap_x - irate_x;
    assign gap_plus = gap_x + orate_x;

    always_comb
    begin
        if (gap_plus > GAP_MAX)
        begin
            gap_clamped = GAP_MAX;
        end
        else if (gap_plus < GAP_MIN)
        begin
            gap_clamped = GAP_MIN;
        end
        else
        begin
            gap_clamped = gap_plus;
        end
    end

    assign room      = (n_reg < CNT_W'(MAX_RESULTS));
    assign go_sample = !gap_reg[GAP_W-1] && room;
    assign go_flush  = started_reg && (gap_reg > 0) && room;
    assign out_free  = !out_valid_reg || pop;

    always_comb
    begin
        if (action_reg == ACT_FLUSH)
        begin
            emit_last = (gap_dec <= 0) || (n_reg == CNT_W'(MAX_RESULTS - 1));
        end
        else
        begin
            emit_last = (gap_dec < 0) || (n_reg == CNT_W'(MAX_RESULTS - 1));
        end
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (mcnt_reg[1:0])
            2'd0:
            begin
                op_a = held_l_reg;
                op_b = gap_x;
            end
            2'd1:
            begin
                op_a = new_l_reg;
                op_b = frac;
            end
            2'd2:
            begin
                op_a = held_r_reg;
                op_b = gap_x;
            end
            default:
            begin
                op_a = new_r_reg;
                op_b = frac;
            end
        endcase
    end

    assign mul_res = PROD_W'(op_a) * PROD_W'(op_b);
    assign prod_x  = ACC_W'(prod_reg);

    assign step_l = div_step(rem_l_reg, dq_l_reg, orate);
    assign step_r = div_step(rem_r_reg, dq_r_reg, orate);

    assign q_l   = dq_l_reg[SAMPLE_BITS-1:0];
    assign q_r   = dq_r_reg[SAMPLE_BITS-1:0];
    assign val_l = (action_reg == ACT_FLUSH) ? held_l_reg
                 : $signed(neg_l_reg ? (~q_l + 1'b1) : q_l);
    assign val_r = (action_reg == ACT_FLUSH) ? held_r_reg
                 : $signed(neg_r_reg ? (~q_r + 1'b1) : q_r);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd_head.action == ACT_FLUSH) ? BK_FLUSH : BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                state_next = go_sample ? BK_MUL : BK_IDLE;
            end
            BK_MUL:
            begin
                if (mcnt_reg == MCNT_W'(MUL_STEPS))
                begin
                    state_next = BK_DSET;
                end
            end
            BK_DSET:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (action_reg == ACT_FLUSH) ? BK_FLUSH : BK_CHECK;
                end
            end
            BK_FLUSH:
            begin
                state_next = go_flush ? BK_EMIT : BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        cmd_pop     = 1'b0;
        emit_fire   = 1'b0;
        sample_done = 1'b0;
        case (state_reg)
            BK_IDLE:  cmd_pop     = cmd_valid;
            BK_CHECK: sample_done = !go_sample;
            BK_EMIT:  emit_fire   = out_free;
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            started_reg   <= 1'b0;
            gap_reg       <= '0;
            held_l_reg    <= '0;
            held_r_reg    <= '0;
            n_reg         <= '0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                n_reg <= '0;
            end
            if (state_reg == BK_CHECK)
            begin
                mcnt_reg <= '0;
            end
            if (state_reg == BK_MUL)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            if (state_reg == BK_DSET)
            begin
                dcnt_reg <= '0;
            end
            if (state_reg == BK_DIV)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (sample_done)
            begin
                held_l_reg  <= new_l_reg;
                held_r_reg  <= new_r_reg;
                started_reg <= 1'b1;
                gap_reg     <= gap_clamped[GAP_W-1:0];
            end
            if (emit_fire)
            begin
                n_reg   <= n_reg + 1'b1;
                gap_reg <= gap_dec[GAP_W-1:0];
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            action_reg <= cmd_head.action;
            new_l_reg  <= cmd_head.left;
            new_r_reg  <= cmd_head.right;
        end
        if (state_reg == BK_CHECK)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        if (state_reg == BK_MUL)
        begin
            if (mcnt_reg < MCNT_W'(MUL_STEPS))
            begin
                prod_reg <= mul_res;
            end
            if (mcnt_reg == MCNT_W'(1) || mcnt_reg == MCNT_W'(2))
            begin
                acc_l_reg <= acc_l_reg + prod_x;
            end
            if (mcnt_reg == MCNT_W'(3) || mcnt_reg == MCNT_W'(4))
            begin
                acc_r_reg <= acc_r_reg + prod_x;
            end
        end
        if (state_reg == BK_DSET)
        begin
            neg_l_reg <= acc_l_reg[ACC_W-1];
            neg_r_reg <= acc_r_reg[ACC_W-1];
            dq_l_reg  <= acc_l_reg[ACC_W-1] ? (~acc_l_reg + 1'b1) : acc_l_reg;
            dq_r_reg  <= acc_r_reg[ACC_W-1] ? (~acc_r_reg + 1'b1) : acc_r_reg;
            rem_l_reg <= '0;
            rem_r_reg <= '0;
        end
        if (state_reg == BK_DIV)
        begin
            rem_l_reg <= step_l[RATE_W+ACC_W-1:ACC_W];
            dq_l_reg  <= step_l[ACC_W-1:0];
            rem_r_reg <= step_r[RATE_W+ACC_W-1:ACC_W];
            dq_r_reg  <= step_r[ACC_W-1:0];
        end
        if (emit_fire)
        begin
            out_l_reg    <= val_l;
            out_r_reg    <= val_r;
            out_last_reg <= emit_last;
        end
    end

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;
    assign last      = out_last_reg;
    assign empty     = !out_valid_reg;

endmodule

/* rtl/stereo_linear_resampler.sv */
// Top level of the stereo linear resampler: register port and block wiring.
`timescale 1ns / 1ps

// Stereo linear resampler. Takes stereo 16-bit sample words at input_rate and
// produces interpolated pairs at output_rate, each equal to
// (held*gap + new*(output_rate-gap)) / output_rate rounded toward zero; the
// very first pair passes through unchanged. A sample word yields zero to
// eight result words, the last one flagged by last. A flush word repeats the
// held pair while output time lags input time and then locks the block until
// reset; later words are accepted and dropped, as are all words while either
// rate is zero or above 48000. Timing: the front end takes a word in any cycle
// the two-entry command queue has room. The back end pops each word, then per
// interpolated pair runs a check, the shared multiplier, a setup, the 36 steps
// of the bit-serial divider and an emit, per flushed pair a check and an emit;
// the divider's 36 steps set the pace. Results wait in an output register, so
// the back end only stalls while that word is not taken. Rates are written
// through the register port at 0x0 (output_rate) and 0x4 (input_rate); the
// user must do so only while the block is idle, which it does not enforce.

module stereo_linear_resampler
    import srs_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input words
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    // result words
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic                          last
);

    logic [RATE_W-1:0] output_rate_reg;
    logic [RATE_W-1:0] input_rate_reg;
    logic              cfg_write;
    logic              rates_ok;

    logic q_push, q_full, q_valid, q_pop;
    cmd_t q_data, q_head;

    // Register port: writes land on the access cycle, reads are immediate.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_rate_reg <= OUTPUT_RATE_RESET;
            input_rate_reg  <= INPUT_RATE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_OUTPUT_RATE: output_rate_reg <= pwdata[RATE_W-1:0];
                REG_INPUT_RATE:  input_rate_reg  <= pwdata[RATE_W-1:0];
                default:
                begin
                    output_rate_reg <= output_rate_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_OUTPUT_RATE: prdata = {{(32 - RATE_W){1'b0}}, output_rate_reg};
            REG_INPUT_RATE:  prdata = {{(32 - RATE_W){1'b0}}, input_rate_reg};
            default:         prdata = '0;
        endcase
    end

    // Drop every word while either rate is out of range.
    assign rates_ok = (output_rate_reg != '0)
                   && (32'(output_rate_reg) <= 32'(MAX_RATE))
                   && (input_rate_reg != '0)
                   && (32'(input_rate_reg) <= 32'(MAX_RATE));

    srs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .rates_ok     (rates_ok),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    srs_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    srs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_head  (q_head),
        .cmd_pop   (q_pop),
        .orate     (output_rate_reg),
        .irate     (input_rate_reg),
        .left_out  (left_out),
        .right_out (right_out),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
